// File: rtl/core/fr4c_pkg.sv
// fr4c_pkg: shared types, constants and helpers for the four-float block codec
// used by fr4c_enc, fr4c_dec and fixed_rate_float4_block_codec; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fr4c_pkg;

  // pipeline depth, including the output register
  localparam int STAGES = 7;
  localparam int CODE_W = 61;
  localparam int EXP_FIELD = 9;

  localparam logic [31:0] NB_MASK = 32'haaaaaaaa;
  localparam logic [31:0] QNAN = 32'h7fc00000;
  localparam logic [3:0] BPV_RESET = 4'd5;
  localparam logic [3:0] BPV_MIN = 4'd1;
  localparam logic [3:0] BPV_MAX = 4'd12;
  // biased exponent limits on decode: scale overflows above, flushes below
  localparam logic [8:0] E9_OVER = 9'd284;
  localparam logic [8:0] E9_UNDER = 9'd8;

  typedef enum logic {
    OP_COMPRESS   = 1'b0,
    OP_DECOMPRESS = 1'b1
  } op_t;

  typedef logic [31:0] word_t;
  typedef word_t [3:0] quad_t;

  // stage load enables and the clamped budget, shared by both datapaths
  typedef struct packed {
    logic [STAGES-2:0] en;
    logic [3:0]        bpv;
  } ctl_t;

  function automatic word_t asr1(word_t v);
    return {v[31], v[31:1]};
  endfunction

  function automatic logic [3:0] clamp_bpv(logic [3:0] b);
    logic [3:0] r;
    r = b;
    if (b < BPV_MIN) r = BPV_MIN;
    if (b > BPV_MAX) r = BPV_MAX;
    return r;
  endfunction

  // bit position of the range flag of coefficient i
  function automatic logic [5:0] seg_offset(logic [3:0] b, logic [1:0] i);
    return 6'(EXP_FIELD) + 6'(i) * (6'(b) + 6'd1);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/fr4c_enc.sv
// fr4c_enc: compression datapath, six register stages plus packing logic
// depends on fr4c_pkg
`timescale 1ns / 1ps
`default_nettype none

module fr4c_enc import fr4c_pkg::*; (
  input  logic              clk,
  input  ctl_t              ctl,
  input  quad_t             value,
  output logic [CODE_W-1:0] code
);

  // stage 1: split each single
  logic              d_neg [4];
  logic              d_nz [4];
  logic [23:0]       d_mant [4];
  logic signed [9:0] d_k [4];
  logic signed [9:0] d_fe [4];

  logic              s1_neg [4];
  logic              s1_nz [4];
  logic [23:0]       s1_mant [4];
  logic signed [9:0] s1_k [4];
  logic signed [9:0] s1_fe [4];

  always_comb begin
    logic [7:0] e;
    logic [22:0] m;
    logic [4:0] msb;
    for (int i = 0; i < 4; i++) begin
      e = value[i][30:23];
      m = value[i][22:0];
      msb = 5'd0;
      for (int j = 0; j < 23; j++) begin
        if (m[j]) msb = 5'(j);
      end
      if (e != 8'd0) msb = 5'd23;
      d_neg[i] = value[i][31];
      d_nz[i] = (e != 8'hff) && !((e == 8'd0) && (m == 23'd0));
      d_mant[i] = {(e != 8'd0), m};
      d_k[i] = (e != 8'd0) ? ($signed({2'b00, e}) - 10'sd150) : -10'sd149;
      d_fe[i] = d_k[i] + $signed({5'b00000, msb}) + 10'sd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_neg <= d_neg;
      s1_nz <= d_nz;
      s1_mant <= d_mant;
      s1_k <= d_k;
      s1_fe <= d_fe;
    end
  end

  // stage 2: block exponent
  logic signed [9:0] emax;
  logic signed [9:0] s2_emax;
  logic              s2_neg [4];
  logic              s2_nz [4];
  logic [23:0]       s2_mant [4];
  logic signed [9:0] s2_k [4];

  always_comb begin
    emax = -10'sd127;
    for (int i = 0; i < 4; i++) begin
      if (s1_nz[i] && (s1_fe[i] > emax)) emax = s1_fe[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_emax <= emax;
      s2_neg <= s1_neg;
      s2_nz <= s1_nz;
      s2_mant <= s1_mant;
      s2_k <= s1_k;
    end
  end

  // stage 3: scale to block-floating integers
  quad_t       sc_c;
  logic [9:0]  e_biased;
  quad_t       s3_c;
  logic [8:0]  s3_e9;

  always_comb begin
    logic signed [10:0] s;
    logic signed [10:0] ns;
    word_t mag;
    for (int i = 0; i < 4; i++) begin
      s = $signed({s2_k[i][9], s2_k[i]}) + 11'sd30 - $signed({s2_emax[9], s2_emax});
      ns = -s;
      mag = '0;
      if (s2_nz[i]) begin
        if (s >= 11'sd0) begin
          mag = (s < 11'sd32) ? (32'(s2_mant[i]) << s[4:0]) : '0;
        end else begin
          mag = (ns < 11'sd32) ? (32'(s2_mant[i]) >> ns[4:0]) : '0;
        end
      end
      sc_c[i] = s2_neg[i] ? (32'd0 - mag) : mag;
    end
    e_biased = s2_emax + 10'sd127;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_c <= sc_c;
      s3_e9 <= e_biased[8:0];
    end
  end

  // stage 4: lifting, first pass
  quad_t      l1;
  quad_t      s4_c;
  logic [8:0] s4_e9;

  always_comb begin
    word_t x, y, z, w;
    x = s3_c[0]; y = s3_c[1]; z = s3_c[2]; w = s3_c[3];
    x = asr1(x + w); w = w - x;
    z = asr1(z + y); y = y - z;
    l1 = {w, z, y, x};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_c <= l1;
      s4_e9 <= s3_e9;
    end
  end

  // stage 5: lifting, second pass
  quad_t      l2;
  quad_t      s5_c;
  logic [8:0] s5_e9;

  always_comb begin
    word_t x, y, z, w;
    x = s4_c[0]; y = s4_c[1]; z = s4_c[2]; w = s4_c[3];
    x = asr1(x + z); z = z - x;
    w = asr1(w + y); y = y - w;
    l2 = {w, z, y, x};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      s5_c <= l2;
      s5_e9 <= s4_e9;
    end
  end

  // stage 6: lifting, final rotation
  quad_t      l3;
  quad_t      s6_c;
  logic [8:0] s6_e9;

  always_comb begin
    word_t y, w;
    y = s5_c[1]; w = s5_c[3];
    w = w + asr1(y);
    y = y - asr1(w);
    l3 = {w, s5_c[2], y, s5_c[0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s6_c <= l3;
      s6_e9 <= s5_e9;
    end
  end

  // negabinary and bit packing
  always_comb begin
    logic [CODE_W-1:0] acc;
    logic [12:0] mk;
    word_t u;
    word_t kept32;
    logic flag;
    logic [12:0] seg;
    mk = (13'd1 << ctl.bpv) - 13'd1;
    acc = CODE_W'(s6_e9);
    for (int i = 0; i < 4; i++) begin
      u = (s6_c[i] + NB_MASK) ^ NB_MASK;
      flag = |u[31:28];
      kept32 = flag ? (u >> (6'd32 - 6'(ctl.bpv))) : (u >> (6'd28 - 6'(ctl.bpv)));
      seg = {kept32[11:0] & mk[11:0], flag};
      acc = acc | (CODE_W'(seg) << seg_offset(ctl.bpv, 2'(i)));
    end
    code = acc;
  end

endmodule

`default_nettype wire

// File: rtl/core/fr4c_dec.sv
// fr4c_dec: decompression datapath, six register stages plus final rounding
// depends on fr4c_pkg
`timescale 1ns / 1ps
`default_nettype none

module fr4c_dec import fr4c_pkg::*; (
  input  logic              clk,
  input  ctl_t              ctl,
  input  logic [CODE_W-1:0] code,
  output quad_t             value
);

  // stage 1: unpack and map from negabinary
  quad_t      un_c;
  quad_t      s1_c;
  logic [8:0] s1_e9;

  always_comb begin
    logic [12:0] mk;
    logic [12:0] seg;
    logic [11:0] kept;
    word_t u;
    mk = (13'd1 << ctl.bpv) - 13'd1;
    for (int i = 0; i < 4; i++) begin
      seg = 13'(code >> seg_offset(ctl.bpv, 2'(i)));
      kept = seg[12:1] & mk[11:0];
      u = seg[0] ? (32'(kept) << (6'd32 - 6'(ctl.bpv)))
                 : (32'(kept) << (6'd28 - 6'(ctl.bpv)));
      un_c[i] = (u ^ NB_MASK) - NB_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      s1_c <= un_c;
      s1_e9 <= code[8:0];
    end
  end

  // stage 2: inverse lifting, rotation
  quad_t      l1;
  quad_t      s2_c;
  logic [8:0] s2_e9;

  always_comb begin
    word_t y, w;
    y = s1_c[1]; w = s1_c[3];
    y = y + asr1(w);
    w = w - asr1(y);
    l1 = {w, s1_c[2], y, s1_c[0]};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[1]) begin
      s2_c <= l1;
      s2_e9 <= s1_e9;
    end
  end

  // stage 3: inverse lifting, second pass
  quad_t      l2;
  quad_t      s3_c;
  logic [8:0] s3_e9;

  always_comb begin
    word_t x, y, z, w;
    x = s2_c[0]; y = s2_c[1]; z = s2_c[2]; w = s2_c[3];
    y = y + w; w = (w << 1) - y;
    z = z + x; x = (x << 1) - z;
    l2 = {w, z, y, x};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[2]) begin
      s3_c <= l2;
      s3_e9 <= s2_e9;
    end
  end

  // stage 4: inverse lifting, last pass
  quad_t      l3;
  quad_t      s4_c;
  logic [8:0] s4_e9;

  always_comb begin
    word_t x, y, z, w;
    x = s3_c[0]; y = s3_c[1]; z = s3_c[2]; w = s3_c[3];
    y = y + z; z = (z << 1) - y;
    w = w + x; x = (x << 1) - w;
    l3 = {w, z, y, x};
  end

  always_ff @(posedge clk) begin
    if (ctl.en[3]) begin
      s4_c <= l3;
      s4_e9 <= s3_e9;
    end
  end

  // stage 5: magnitude and leading one
  word_t      mg_mag [4];
  logic [4:0] mg_p [4];
  word_t      s5_mag [4];
  logic [4:0] s5_p [4];
  logic       s5_neg [4];
  logic       s5_zero [4];
  logic [8:0] s5_e9;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mg_mag[i] = s4_c[i][31] ? (32'd0 - s4_c[i]) : s4_c[i];
      mg_p[i] = 5'd0;
      for (int j = 0; j < 32; j++) begin
        if (mg_mag[i][j]) mg_p[i] = 5'(j);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[4]) begin
      for (int i = 0; i < 4; i++) begin
        s5_mag[i] <= mg_mag[i];
        s5_p[i] <= mg_p[i];
        s5_neg[i] <= s4_c[i][31];
        s5_zero[i] <= (s4_c[i] == '0);
      end
      s5_e9 <= s4_e9;
    end
  end

  // stage 6: round integer to a 24-bit significand
  logic [23:0] rn_m [4];
  logic [5:0]  rn_p [4];
  logic [23:0] s6_m [4];
  logic [5:0]  s6_p [4];
  logic        s6_neg [4];
  logic        s6_zero [4];
  logic [8:0]  s6_e9;

  always_comb begin
    word_t norm;
    logic ru;
    logic [24:0] msum;
    for (int i = 0; i < 4; i++) begin
      norm = s5_mag[i] << (5'd31 - s5_p[i]);
      ru = norm[7] && ((|norm[6:0]) || norm[8]);
      msum = 25'(norm[31:8]) + 25'(ru);
      if (msum[24]) begin
        rn_m[i] = 24'h800000;
        rn_p[i] = 6'(s5_p[i]) + 6'd1;
      end else begin
        rn_m[i] = msum[23:0];
        rn_p[i] = 6'(s5_p[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[5]) begin
      s6_m <= rn_m;
      s6_p <= rn_p;
      s6_neg <= s5_neg;
      s6_zero <= s5_zero;
      s6_e9 <= s5_e9;
    end
  end

  // apply block scale, with overflow and subnormal rounding
  always_comb begin
    logic signed [10:0] biased;
    logic signed [10:0] sh;
    logic [47:0] wide;
    logic [23:0] q;
    logic ru;
    for (int i = 0; i < 4; i++) begin
      biased = $signed({5'b00000, s6_p[i]}) + $signed({2'b00, s6_e9}) - 11'sd30;
      sh = 11'sd1 - biased;
      wide = {s6_m[i], 24'd0} >> sh[4:0];
      q = wide[47:24];
      ru = wide[23] && ((|wide[22:0]) || q[0]);
      if (s6_e9 > E9_OVER) begin
        value[i] = s6_zero[i] ? QNAN : {s6_neg[i], 8'hff, 23'd0};
      end else if (s6_zero[i]) begin
        value[i] = '0;
      end else if (s6_e9 < E9_UNDER) begin
        value[i] = {s6_neg[i], 31'd0};
      end else if (biased >= 11'sd255) begin
        value[i] = {s6_neg[i], 8'hff, 23'd0};
      end else if (biased >= 11'sd1) begin
        value[i] = {s6_neg[i], biased[7:0], s6_m[i][22:0]};
      end else if (sh > 11'sd25) begin
        value[i] = {s6_neg[i], 31'd0};
      end else begin
        value[i] = {s6_neg[i], 7'd0, q + 24'(ru)};
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/fixed_rate_float4_block_codec.sv
// fixed_rate_float4_block_codec: top level, stage control, config register, output register
// depends on fr4c_pkg, fr4c_enc, fr4c_dec
//
//   channel   signals                                       direction
//   input     in_valid, in_stall (out), op, in_value_0..3, in_code    in
//   output    out_valid, out_stall (in), out_code, out_value_0..3    out
//   config    cfg_wen, cfg_wdata                                 in
//
// one transaction per cycle while out_stall does not hold the pipeline; a result passes
// through the six register stages of each datapath and then the output register
// rst (synchronous) empties the pipeline and sets bits_per_value to 5
// a stage loads when it is empty or its successor loads, so bubbles close up
// under out_stall and in_stall rises only when all seven stages hold data
`timescale 1ns / 1ps
`default_nettype none

module fixed_rate_float4_block_codec import fr4c_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              op,
  input  logic [31:0]       in_value_0,
  input  logic [31:0]       in_value_1,
  input  logic [31:0]       in_value_2,
  input  logic [31:0]       in_value_3,
  input  logic [CODE_W-1:0] in_code,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CODE_W-1:0] out_code,
  output logic [31:0]       out_value_0,
  output logic [31:0]       out_value_1,
  output logic [31:0]       out_value_2,
  output logic [31:0]       out_value_3,
  input  logic              cfg_wen,
  input  logic [3:0]        cfg_wdata
);

  logic [3:0]        bits_per_value;
  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] en;
  op_t               op_p [STAGES-1];
  ctl_t              ctl;
  quad_t             in_quad;
  logic [CODE_W-1:0] enc_code;
  quad_t             dec_value;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_value <= BPV_RESET;
    end else if (cfg_wen) begin
      bits_per_value <= cfg_wdata;
    end
  end

  // stage load enables
  always_comb begin
    en[STAGES-1] = !vld[STAGES-1] || !out_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = vld[STAGES-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // operation travels with the data
  always_ff @(posedge clk) begin
    if (en[0]) op_p[0] <= op_t'(op);
    for (int i = 1; i < STAGES - 1; i++) begin
      if (en[i]) op_p[i] <= op_p[i-1];
    end
  end

  assign ctl.en = en[STAGES-2:0];
  assign ctl.bpv = clamp_bpv(bits_per_value);
  assign in_quad = {in_value_3, in_value_2, in_value_1, in_value_0};

  fr4c_enc u_enc (
    .clk   (clk),
    .ctl   (ctl),
    .value (in_quad),
    .code  (enc_code)
  );

  fr4c_dec u_dec (
    .clk   (clk),
    .ctl   (ctl),
    .code  (in_code),
    .value (dec_value)
  );

  // output register, unused fields zero
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      if (op_p[STAGES-2] == OP_COMPRESS) begin
        out_code <= enc_code;
        out_value_0 <= '0;
        out_value_1 <= '0;
        out_value_2 <= '0;
        out_value_3 <= '0;
      end else begin
        out_code <= '0;
        out_value_0 <= dec_value[0];
        out_value_1 <= dec_value[1];
        out_value_2 <= dec_value[2];
        out_value_3 <= dec_value[3];
      end
    end
  end

`ifndef SYNTHESIS
  // input backpressure only when every stage is occupied
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (&vld)) else $error("in_stall with an empty stage");

  // a result carries either a code word or values, never both
  a_fields_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_code == '0) ||
                   ((out_value_0 == '0) && (out_value_1 == '0) &&
                    (out_value_2 == '0) && (out_value_3 == '0))))
    else $error("code word and values both nonzero");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall)) else $error("pipeline not empty after reset");
`endif

endmodule

`default_nettype wire
